// ----- hw/rtl/cpt_pkg.sv -----
// ----------------------------------------------------------------------------
// cpt_pkg: shared definitions for the capture period tachometer
// Register indexes, field widths and reset values of the configuration.
// ----------------------------------------------------------------------------
package cpt_pkg;

	localparam int CLK_W   = 27;
	localparam int PPR_W   = 7;
	localparam int NUM_W   = 33;
	localparam int SPEED_W = 33;
	localparam int CFG_W   = 27;
	localparam int IDX_W   = 1;

	localparam logic [IDX_W-1:0] REG_CLOCK_HZ      = 1'b0;
	localparam logic [IDX_W-1:0] REG_EDGES_PER_REV = 1'b1;

	localparam logic [CLK_W-1:0] CLOCK_HZ_RESET = 27'd16000000;
	localparam logic [PPR_W-1:0] PPR_RESET      = 7'd1;

endpackage

// ----- hw/rtl/capture_period_tachometer_top.sv -----
// ----------------------------------------------------------------------------
// capture_period_tachometer_top: two-channel capture period tachometer
// Each request passes the period subtract, the period multiply, a divider
// start, 33 serial divider steps and a load of the result.
// A new request is taken only once the last result has been handed off at
// the output, so the 33-step serial divider and any output wait set the rate.
// Reset clears the stamps to zero and loads the clock rate and edges per
// revolution registers with their defaults.
// ----------------------------------------------------------------------------
module capture_period_tachometer_top #(
	parameter int STAMP_BITS = 16,
	parameter int CHANNELS   = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// [STAMP_BITS-1:0] capture_time, zero padded to bytes
	input  logic [((STAMP_BITS+7)/8)*8-1:0] s_axis_tdata,
	// [0] channel
	input  logic                         s_axis_tuser,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [STAMP_BITS-1:0] period_ticks, then speed_rpm (33 bits), zero padded
	output logic [((STAMP_BITS+cpt_pkg::SPEED_W+7)/8)*8-1:0] m_axis_tdata,
	// [0] channel_out
	output logic                         m_axis_tuser,
	input  logic                         cfg_we,
	input  logic [cpt_pkg::IDX_W-1:0]    cfg_index,
	input  logic [cpt_pkg::CFG_W-1:0]    cfg_data
);

	localparam int OUT_W  = ((STAMP_BITS + cpt_pkg::SPEED_W + 7) / 8) * 8;
	localparam int DEN_W  = STAMP_BITS + cpt_pkg::PPR_W;
	localparam int SLOT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SEND
	} state_t;

	state_t                      state_q;
	logic [cpt_pkg::CLK_W-1:0]   clock_hz_q;
	logic [cpt_pkg::PPR_W-1:0]   ppr_q;
	logic [STAMP_BITS-1:0]       stamp_q [CHANNELS];
	logic [STAMP_BITS-1:0]       period_q;
	logic                        channel_q;
	logic [DEN_W-1:0]            den_q;
	logic [cpt_pkg::NUM_W-1:0]   num_q;
	logic                        den_zero_q;
	logic                        div_start_q;
	logic                        out_valid_q;
	logic [cpt_pkg::SPEED_W-1:0] speed_q;

	logic [SLOT_W-1:0]           slot;
	logic [STAMP_BITS-1:0]       capture_time;
	logic                        accept;
	logic                        div_done;
	logic [cpt_pkg::NUM_W-1:0]   quot;
	logic [cpt_pkg::NUM_W-1:0]   clk_x64;
	logic [cpt_pkg::NUM_W-1:0]   clk_x4;
	logic [DEN_W-1:0]            product;

	assign capture_time = s_axis_tdata[STAMP_BITS-1:0];
	assign slot         = (CHANNELS == 1) ? '0 : SLOT_W'(s_axis_tuser);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept       = s_axis_tvalid && s_axis_tready;

	assign clk_x64 = cpt_pkg::NUM_W'(clock_hz_q) << 6;
	assign clk_x4  = cpt_pkg::NUM_W'(clock_hz_q) << 2;
	assign product = DEN_W'(period_q) * DEN_W'(ppr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= cpt_pkg::CLOCK_HZ_RESET;
			ppr_q      <= cpt_pkg::PPR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cpt_pkg::REG_CLOCK_HZ:      clock_hz_q <= cfg_data[cpt_pkg::CLK_W-1:0];
				cpt_pkg::REG_EDGES_PER_REV: ppr_q      <= cfg_data[cpt_pkg::PPR_W-1:0];
				default:                    ppr_q      <= ppr_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CHANNELS; k++) begin
				stamp_q[k] <= '0;
			end
		end else if (accept) begin
			stamp_q[slot] <= capture_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						period_q  <= capture_time - stamp_q[slot];
						channel_q <= s_axis_tuser;
						state_q   <= ST_MUL;
					end
				end
				ST_MUL: begin
					den_q       <= product;
					den_zero_q  <= (product == '0);
					num_q       <= clk_x64 - clk_x4;
					div_start_q <= 1'b1;
					state_q     <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						speed_q     <= den_zero_q ? '0 : quot;
						out_valid_q <= 1'b1;
						state_q     <= ST_SEND;
					end
				end
				ST_SEND: begin
					if (m_axis_tready) begin
						out_valid_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	cpt_div #(
		.NUM_W(cpt_pkg::NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start_q),
		.num   (num_q),
		.den   (den_q),
		.done  (div_done),
		.quot  (quot)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = channel_q;
	assign m_axis_tdata  = OUT_W'({speed_q, period_q});

endmodule

// ----- hw/rtl/cpt_div.sv -----
// ----------------------------------------------------------------------------
// cpt_div: iterative restoring divider
// One quotient bit per cycle through a shared subtract and compare unit.
// ----------------------------------------------------------------------------
module cpt_div #(
	parameter int NUM_W = 33,
	parameter int DEN_W = 23
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] qn_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic             done_q;

	logic [DEN_W:0] shifted;
	logic [DEN_W:0] diff;
	logic           fits;

	assign shifted = {rem_q, qn_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = ~diff[DEN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						qn_q    <= num;
						den_q   <= den;
						rem_q   <= '0;
						cnt_q   <= CNT_W'(NUM_W - 1);
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					qn_q  <= {qn_q[NUM_W-2:0], fits};
					rem_q <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign quot = qn_q;

endmodule

// ----- test/tb_capture_period_tachometer_top.sv -----
// ----------------------------------------------------------------------------
// tb_capture_period_tachometer_top: capture period tachometer testbench
// Streams capture requests into the block and checks every measurement. A
// scoreboard predicts period and speed from its own copy of the stamps and
// the registers. The run covers a directed set of edge cases, register
// extremes and random sequences under several sender and receiver idle
// profiles, one long output hold-off and full drains.
// ----------------------------------------------------------------------------
module tb_capture_period_tachometer_top;

	localparam int STAMP_W   = 16;
	localparam int IN_W      = ((STAMP_W + 7) / 8) * 8;
	localparam int OUT_W     = ((STAMP_W + cpt_pkg::SPEED_W + 7) / 8) * 8;
	localparam int MAX_CYCLE = 600000;
	localparam int HOLD_LEN  = 400;

	typedef struct packed {
		logic                        channel;
		logic [STAMP_W-1:0]          period;
		logic [cpt_pkg::SPEED_W-1:0] speed;
	} meas_t;

	class tach_scoreboard;
		logic [STAMP_W-1:0]        last_stamp [2];
		logic [cpt_pkg::CLK_W-1:0] clock_hz;
		logic [cpt_pkg::PPR_W-1:0] ppr;
		meas_t                     expected_meas [$];
		int                        errors;

		function new();
			last_stamp[0] = '0;
			last_stamp[1] = '0;
			clock_hz      = cpt_pkg::CLOCK_HZ_RESET;
			ppr           = cpt_pkg::PPR_RESET;
			errors        = 0;
		endfunction

		function void set_register(logic [cpt_pkg::IDX_W-1:0] idx,
			logic [cpt_pkg::CFG_W-1:0] value);
			if (idx == cpt_pkg::REG_CLOCK_HZ)
				clock_hz = value[cpt_pkg::CLK_W-1:0];
			else if (idx == cpt_pkg::REG_EDGES_PER_REV)
				ppr = value[cpt_pkg::PPR_W-1:0];
		endfunction

		function logic [cpt_pkg::SPEED_W-1:0] speed_of_period(logic [STAMP_W-1:0] period);
			logic [63:0] num;
			logic [63:0] div;
			num = 64'(clock_hz) * 64'd60;
			div = 64'(period) * 64'(ppr);
			if (div == 0)
				return '0;
			return cpt_pkg::SPEED_W'(num / div);
		endfunction

		function void note_capture(logic ch, logic [STAMP_W-1:0] stamp);
			meas_t m;
			m.channel = ch;
			m.period  = stamp - last_stamp[ch];
			m.speed   = speed_of_period(m.period);
			last_stamp[ch] = stamp;
			expected_meas.push_back(m);
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_measurement(logic ch, logic [STAMP_W-1:0] period,
			logic [cpt_pkg::SPEED_W-1:0] speed);
			meas_t m;
			if (expected_meas.size() == 0) begin
				report($sformatf("unexpected result ch=%0d period=%0d speed=%0d",
					ch, period, speed));
			end else begin
				m = expected_meas.pop_front();
				if (ch !== m.channel)
					report($sformatf("channel_out exp %0d got %0d", m.channel, ch));
				if (period !== m.period)
					report($sformatf("period_ticks exp %0d got %0d", m.period, period));
				if (speed !== m.speed)
					report($sformatf("speed_rpm exp %0d got %0d", m.speed, speed));
			end
		endtask

		function int pending();
			return expected_meas.size();
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        s_axis_tvalid;
	logic                        s_axis_tready;
	logic [IN_W-1:0]             s_axis_tdata;
	logic                        s_axis_tuser;
	logic                        m_axis_tvalid;
	logic                        m_axis_tready;
	logic [OUT_W-1:0]            m_axis_tdata;
	logic                        m_axis_tuser;
	logic                        cfg_we;
	logic [cpt_pkg::IDX_W-1:0]   cfg_index;
	logic [cpt_pkg::CFG_W-1:0]   cfg_data;

	tach_scoreboard      sb;
	int                  send_idle_pct;
	int                  recv_stall_pct;
	bit                  hold_req;
	int                  hold_left;
	int                  cycle_count;
	logic [STAMP_W-1:0]  gen_last [2];

	capture_period_tachometer_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLE) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** capture_period_tachometer_top: FAILED **");
			$finish;
		end
	end

	// output side: random stalls plus a long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		hold_left     = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_measurement(m_axis_tuser, m_axis_tdata[STAMP_W-1:0],
				m_axis_tdata[STAMP_W+cpt_pkg::SPEED_W-1:STAMP_W]);
	end

	task send_capture(logic ch, logic [STAMP_W-1:0] stamp);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= ch;
		s_axis_tdata  <= IN_W'(stamp);
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_capture(ch, stamp);
		gen_last[ch] = stamp;
	endtask

	task drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task write_reg(logic [cpt_pkg::IDX_W-1:0] idx, logic [cpt_pkg::CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_register(idx, value);
		@(posedge clk);
	endtask

	task set_both(logic [cpt_pkg::CFG_W-1:0] hz, logic [cpt_pkg::CFG_W-1:0] ppr);
		drain();
		write_reg(cpt_pkg::REG_CLOCK_HZ, hz);
		write_reg(cpt_pkg::REG_EDGES_PER_REV, ppr);
	endtask

	// mostly near the last stamp so speeds stay large, some repeats and wraps
	task send_random(int count);
		logic               ch;
		logic [STAMP_W-1:0] stamp;
		int                 mode;
		for (int i = 0; i < count; i++) begin
			ch   = 1'($urandom_range(1));
			mode = $urandom_range(99);
			if (mode < 15)
				stamp = gen_last[ch];
			else if (mode < 45)
				stamp = gen_last[ch] + STAMP_W'($urandom_range(255, 1));
			else if (mode < 55)
				stamp = gen_last[ch] - STAMP_W'($urandom_range(255, 1));
			else
				stamp = STAMP_W'($urandom);
			send_capture(ch, stamp);
		end
	endtask

	task set_idle(int send_pct, int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	initial begin
		sb            = new();
		cycle_count   = 0;
		hold_req      = 1'b0;
		gen_last[0]   = '0;
		gen_last[1]   = '0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		set_idle(0, 0);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset stamps, wrap, equal stamps, extremes
		send_capture(1'b0, 16'h0000);
		send_capture(1'b1, 16'hFFFF);
		send_capture(1'b0, 16'h0001);
		send_capture(1'b0, 16'h0001);
		send_capture(1'b1, 16'h0000);
		send_capture(1'b1, 16'h8000);
		send_capture(1'b0, 16'hAAAA);
		send_capture(1'b0, 16'h5555);
		send_capture(1'b1, 16'h7FFF);
		set_both(27'h7FFFFFF, 27'd1);
		send_capture(1'b0, 16'h5556);
		send_capture(1'b1, 16'h7FFF);
		send_capture(1'b1, 16'h8000);
		drain();
		write_reg(cpt_pkg::REG_EDGES_PER_REV, 27'h7FFFFFF);
		send_capture(1'b0, 16'hFFFF);
		send_capture(1'b0, 16'h0000);
		set_both(27'd100000000, 27'd64);
		send_capture(1'b1, 16'h8001);
		send_capture(1'b1, 16'h0001);
		set_both(27'd16000000, 27'd0);
		send_capture(1'b0, 16'h1234);
		set_both(27'd0, 27'd5);
		send_capture(1'b1, 16'h0100);
		send_capture(1'b0, 16'h1300);

		set_both(27'd16000000, 27'd1);
		set_idle(0, 0);
		send_random(200);

		set_both(27'd100000000, 27'd64);
		set_idle(50, 0);
		send_random(200);

		set_both(cpt_pkg::CFG_W'($urandom_range(27'h7FFFFFF, 1)),
			cpt_pkg::CFG_W'($urandom_range(127)));
		set_idle(0, 50);
		send_random(60);
		hold_req = 1'b1;
		send_random(40);
		send_random(100);

		set_both(27'd1, 27'd2);
		set_idle(18, 18);
		send_random(75);
		drain();
		send_random(75);

		set_both(27'h7FFFFFF, 27'd0);
		send_random(100);

		set_both(cpt_pkg::CFG_W'($urandom_range(27'h7FFFFFF)),
			cpt_pkg::CFG_W'($urandom_range(64, 1)));
		set_idle(0, 0);
		send_random(100);

		drain();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("** capture_period_tachometer_top: PASSED **");
		else
			$display("** capture_period_tachometer_top: FAILED **");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/cpt_pkg.sv
hw/rtl/cpt_div.sv
hw/rtl/capture_period_tachometer_top.sv
test/tb_capture_period_tachometer_top.sv
